### rtl/core/rotator_serial_link_top_defines.svh
// ---------------------------------------------------------------------------
// Assertion macros for the rotator serial link block
// ---------------------------------------------------------------------------
`ifndef ROTATOR_SERIAL_LINK_TOP_DEFINES_SVH
`define ROTATOR_SERIAL_LINK_TOP_DEFINES_SVH

// Clocked on clk_i, quiet while rst_ni is low.
`define RSL_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Check a condition on every result the output channel presents.
`define RSL_ASSERT_OUT(lbl, cond, msg) \
  `RSL_ASSERT(lbl, m_axis_tvalid |-> (cond), msg)

`endif

### rtl/core/rsl_pkg.sv
// ---------------------------------------------------------------------------
// rsl_pkg
// Shared types and constants of the rotator serial link block.
// ---------------------------------------------------------------------------
package rsl_pkg;

  localparam int TIMER_WIDTH_DFLT = 16;
  localparam int JOB_DEPTH_DFLT   = 4;

  localparam int CFG_WIDTH  = 16;
  localparam int IN_TDATA_W = 24;
  localparam int OUT_TDATA_W = 24;

  localparam logic [CFG_WIDTH-1:0] POLL_INTERVAL_RST = 16'd800;
  localparam logic [CFG_WIDTH-1:0] DEAD_TIME_RST     = 16'd2500;
  localparam logic [CFG_WIDTH-1:0] EXEC_DELAY_RST    = 16'd500;

  localparam logic [7:0] CHAR_A    = 8'h41;
  localparam logic [7:0] CHAR_I    = 8'h49;
  localparam logic [7:0] CHAR_M    = 8'h4D;
  localparam logic [7:0] CHAR_P    = 8'h50;
  localparam logic [7:0] CHAR_ONE  = 8'h31;
  localparam logic [7:0] CHAR_ZERO = 8'h30;
  localparam logic [7:0] CHAR_NINE = 8'h39;
  localparam logic [7:0] CHAR_SEMI = 8'h3B;

  localparam logic [10:0] DEG_FULL = 11'd360;

  typedef enum logic [1:0] {
    OP_RX   = 2'd0,
    OP_TICK = 2'd1,
    OP_TURN = 2'd2,
    OP_STOP = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    REG_POLL_INTERVAL = 2'd0,
    REG_DEAD_TIME     = 2'd1,
    REG_EXEC_DELAY    = 2'd2
  } cfg_reg_e;

  typedef enum logic [1:0] {
    JOB_NONE = 2'd0,
    JOB_TICK = 2'd1,
    JOB_TURN = 2'd2,
    JOB_STOP = 2'd3
  } job_kind_e;

  typedef struct packed {
    logic       link_chg;
    logic       az_chg;
    logic       link_up;
    logic       az_valid;
    logic [8:0] azimuth;
  } status_t;

  typedef struct packed {
    job_kind_e   kind;
    logic        am;      // tick sends the execute command
    logic        ai;      // tick sends the status poll
    logic [15:0] target;
    status_t     st;
  } job_t;

endpackage

### rtl/core/rotator_serial_link_top.sv
// ---------------------------------------------------------------------------
// rotator_serial_link_top
// Rotator control link engine: deframes replies, polls, sends turn commands.
// ---------------------------------------------------------------------------
// Input stream: one event per request, tuser selects received byte, ms tick,
// turn or stop; tdata carries the byte and the signed turn target.
// Output stream: one result per transmitted byte, or a single result with
// tuser low when the event sends nothing; tlast marks the event's final result.
// Registers poll interval, dead time and execute delay are to be written through
// the plain write port only while the block is idle; the block does not enforce it.
// An event passes through the job queue and the current-job register before its
// first result is registered; a turn first waits while its remainder and digits
// take three pipeline steps. One result per cycle leaves the output register
// while the receiver takes them; an event yields 1, 4 or 8 results, a turn 7.
// A four-entry job queue lets the input side keep accepting while the
// receiver stalls; input tready drops only once the queue is full.
// Reset clears the link state, the timers (first tick polls) and the queue;
// no clearing pass is needed.
// ---------------------------------------------------------------------------
module rotator_serial_link_top import rsl_pkg::*; #(
  parameter int TimerWidth = TIMER_WIDTH_DFLT,
  parameter int JobDepth   = JOB_DEPTH_DFLT
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   cfg_we_i,
  input  logic [1:0]             cfg_idx_i,
  input  logic [CFG_WIDTH-1:0]   cfg_data_i,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // [7:0] rx_byte, [23:8] target_deg
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  // [1:0] operation
  input  logic [1:0]             s_axis_tuser,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // [7:0] tx_byte, [16:8] azimuth, [17] azimuth_valid, [18] link_up,
  // [19] azimuth_changed, [20] link_changed, [23:21] zero
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,
  // [0] tx_valid
  output logic                   m_axis_tuser,
  output logic                   m_axis_tlast
);

  logic push, q_ready, q_valid, pop;
  job_t push_job, head_job;

  rsl_front #(.TimerWidth(TimerWidth)) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_data_i   (cfg_data_i),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_op_i      (s_axis_tuser),
    .in_rx_byte_i (s_axis_tdata[7:0]),
    .in_target_i  (s_axis_tdata[23:8]),
    .q_ready_i    (q_ready),
    .push_o       (push),
    .job_o        (push_job)
  );

  rsl_fifo #(.Depth(JobDepth)) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .data_i  (push_job),
    .ready_o (q_ready),
    .pop_i   (pop),
    .valid_o (q_valid),
    .data_o  (head_job)
  );

  rsl_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .job_i       (head_job),
    .pop_o       (pop),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .out_data_o  (m_axis_tdata),
    .out_tx_o    (m_axis_tuser),
    .out_last_o  (m_axis_tlast)
  );

endmodule

### rtl/core/rsl_front.sv
// ---------------------------------------------------------------------------
// rsl_front
// Accepts events, runs the deframer and timers, and queues one job per event.
// ---------------------------------------------------------------------------
module rsl_front import rsl_pkg::*; #(
  parameter int TimerWidth = TIMER_WIDTH_DFLT
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [1:0]           cfg_idx_i,
  input  logic [CFG_WIDTH-1:0] cfg_data_i,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [1:0]           in_op_i,
  input  logic [7:0]           in_rx_byte_i,
  input  logic [15:0]          in_target_i,
  input  logic                 q_ready_i,
  output logic                 push_o,
  output job_t                 job_o
);

  localparam logic [32:0] TimerMax = (33'd1 << TimerWidth) - 33'd1;

  function automatic logic [TimerWidth-1:0] fit_timer(logic [CFG_WIDTH-1:0] v);
    logic [32:0] ext;
    ext = 33'(v);
    if (ext > TimerMax) return '1;
    return ext[TimerWidth-1:0];
  endfunction

  function automatic logic is_digit(logic [7:0] c);
    return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
  endfunction

  logic [CFG_WIDTH-1:0]  poll_ivl_q, dead_time_q, exec_dly_q;
  logic [7:0]            recent_q [3];
  logic [7:0]            recent_d [3];
  logic [1:0]            held_q, held_d;
  logic [8:0]            az_q, az_d;
  logic                  known_q, known_d;
  logic                  link_q, link_d;
  logic [TimerWidth-1:0] poll_q, poll_d;
  logic [TimerWidth-1:0] sil_q, sil_d;
  logic [TimerWidth-1:0] exec_q, exec_d;
  logic                  pend_q, pend_d;

  logic                  accept;
  logic [10:0]           frame_deg;
  logic [8:0]            frame_az;
  logic                  frame_hit;
  logic [TimerWidth-1:0] sil_inc;
  logic                  am, ai, az_chg, link_chg;
  job_kind_e             kind;

  assign in_ready_o = q_ready_i;
  assign accept     = in_valid_i && q_ready_i;
  assign push_o     = accept;

  assign frame_deg = 11'(recent_q[0][3:0]) * 11'd100 + 11'(recent_q[1][3:0]) * 11'd10
                   + 11'(recent_q[2][3:0]);
  assign frame_hit = (in_rx_byte_i == CHAR_SEMI) && is_digit(recent_q[0])
                   && is_digit(recent_q[1]) && is_digit(recent_q[2])
                   && (frame_deg <= DEG_FULL);
  // full circle reads as north
  assign frame_az  = (frame_deg == DEG_FULL) ? 9'd0 : frame_deg[8:0];
  assign sil_inc   = (sil_q == '1) ? sil_q : sil_q + 1'b1;

  always_comb begin
    recent_d = recent_q;
    held_d   = held_q;
    az_d     = az_q;
    known_d  = known_q;
    link_d   = link_q;
    poll_d   = poll_q;
    sil_d    = sil_q;
    exec_d   = exec_q;
    pend_d   = pend_q;
    am       = 1'b0;
    ai       = 1'b0;
    az_chg   = 1'b0;
    link_chg = 1'b0;
    kind     = JOB_NONE;
    if (accept) begin
      unique case (op_e'(in_op_i))
        OP_RX: begin
          if (held_q != 2'd3) begin
            recent_d[held_q] = in_rx_byte_i;
            held_d = held_q + 2'd1;
          end else if (frame_hit) begin
            held_d = 2'd0;
            sil_d  = '0;
            if (!link_q) begin
              link_d   = 1'b1;
              link_chg = 1'b1;
            end
            if (!known_q || (az_q != frame_az)) begin
              az_d    = frame_az;
              known_d = 1'b1;
              az_chg  = 1'b1;
            end
          end else begin
            // slide the window by one byte
            recent_d[0] = recent_q[1];
            recent_d[1] = recent_q[2];
            recent_d[2] = in_rx_byte_i;
          end
        end
        OP_TICK: begin
          sil_d = sil_inc;
          if (pend_q) begin
            if (exec_q <= TimerWidth'(1)) begin
              exec_d = '0;
              pend_d = 1'b0;
              am     = 1'b1;
            end else begin
              exec_d = exec_q - 1'b1;
            end
          end
          if (poll_q == '0) begin
            if (link_q && (33'(sil_inc) > 33'(dead_time_q))) begin
              link_d   = 1'b0;
              link_chg = 1'b1;
              known_d  = 1'b0;
              az_d     = 9'd0;
              az_chg   = 1'b1;
            end
            ai     = 1'b1;
            poll_d = (poll_ivl_q == '0) ? '0 : fit_timer(poll_ivl_q) - 1'b1;
          end else begin
            poll_d = poll_q - 1'b1;
          end
          kind = (am || ai) ? JOB_TICK : JOB_NONE;
        end
        OP_TURN: begin
          exec_d = fit_timer(exec_dly_q);
          pend_d = 1'b1;
          kind   = JOB_TURN;
        end
        OP_STOP: begin
          kind = JOB_STOP;
        end
        default: begin
          kind = JOB_NONE;
        end
      endcase
    end
  end

  always_comb begin
    job_o.kind        = kind;
    job_o.am          = am;
    job_o.ai          = ai;
    job_o.target      = in_target_i;
    job_o.st.link_chg = link_chg;
    job_o.st.az_chg   = az_chg;
    job_o.st.link_up  = link_d;
    job_o.st.az_valid = known_d;
    job_o.st.azimuth  = known_d ? az_d : 9'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      poll_ivl_q  <= POLL_INTERVAL_RST;
      dead_time_q <= DEAD_TIME_RST;
      exec_dly_q  <= EXEC_DELAY_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_POLL_INTERVAL: poll_ivl_q  <= cfg_data_i;
        REG_DEAD_TIME:     dead_time_q <= cfg_data_i;
        REG_EXEC_DELAY:    exec_dly_q  <= cfg_data_i;
        default: begin
          // unmapped index: drop the write
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      recent_q <= '{default: 8'h00};
      held_q   <= 2'd0;
      az_q     <= 9'd0;
      known_q  <= 1'b0;
      link_q   <= 1'b0;
      poll_q   <= '0;
      sil_q    <= '0;
      exec_q   <= '0;
      pend_q   <= 1'b0;
    end else begin
      recent_q <= recent_d;
      held_q   <= held_d;
      az_q     <= az_d;
      known_q  <= known_d;
      link_q   <= link_d;
      poll_q   <= poll_d;
      sil_q    <= sil_d;
      exec_q   <= exec_d;
      pend_q   <= pend_d;
    end
  end

endmodule

### rtl/core/rsl_fifo.sv
// ---------------------------------------------------------------------------
// rsl_fifo
// Short job queue between the event front end and the transmit back end.
// ---------------------------------------------------------------------------
module rsl_fifo import rsl_pkg::*; #(
  parameter int Depth = JOB_DEPTH_DFLT
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic push_i,
  input  job_t data_i,
  output logic ready_o,
  input  logic pop_i,
  output logic valid_o,
  output job_t data_o
);

  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  job_t             slots_q [Depth];
  logic [AddrW-1:0] wptr_q, rptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_push, do_pop;

  assign ready_o = (cnt_q != FullCnt);
  assign valid_o = (cnt_q != '0);
  assign data_o  = slots_q[rptr_q];
  assign do_push = push_i && ready_o;
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (do_push) slots_q[wptr_q] <= data_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (do_push) wptr_q <= (wptr_q == LastAddr) ? '0 : wptr_q + 1'b1;
      if (do_pop)  rptr_q <= (rptr_q == LastAddr) ? '0 : rptr_q + 1'b1;
      if (do_push && !do_pop)      cnt_q <= cnt_q + 1'b1;
      else if (do_pop && !do_push) cnt_q <= cnt_q - 1'b1;
    end
  end

endmodule

### rtl/core/rsl_back.sv
// ---------------------------------------------------------------------------
// rsl_back
// Expands queued jobs into result items in an output register, one per cycle while it is free.
// ---------------------------------------------------------------------------
module rsl_back import rsl_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   q_valid_i,
  input  job_t                   job_i,
  output logic                   pop_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [OUT_TDATA_W-1:0] out_data_o,
  output logic                   out_tx_o,
  output logic                   out_last_o
);

  job_t        cur_q;
  logic        cur_vld_q;
  logic [2:0]  idx_q, last_idx_q;
  logic [1:0]  calc_q;
  logic [16:0] x_q;
  logic [7:0]  quo_q;
  logic [8:0]  rem_q;
  logic [3:0]  dig_q [3];

  logic                   out_vld_q, out_tx_q, out_last_q;
  logic [OUT_TDATA_W-1:0] out_data_q;

  logic        out_free, fire, fire_last;
  logic [2:0]  job_last;
  logic [30:0] prod;
  logic [16:0] quo_mul;
  logic [17:0] diff;
  logic [8:0]  rem_d;
  logic [1:0]  hund;
  logic [6:0]  rem100;
  logic [3:0]  tens;
  logic [3:0]  units;
  logic [7:0]  tx_byte;
  logic        tx_flag;

  assign out_free  = !out_vld_q || out_ready_i;
  assign fire      = cur_vld_q && (calc_q == 2'd0) && out_free;
  assign fire_last = fire && (idx_q == last_idx_q);
  assign pop_o     = q_valid_i && (!cur_vld_q || fire_last);

  always_comb begin
    case (job_i.kind)
      JOB_TICK: job_last = (job_i.am && job_i.ai) ? 3'd7 : 3'd3;
      JOB_TURN: job_last = 3'd6;
      default:  job_last = 3'd0;
    endcase
  end

  // Remainder by 360: reciprocal estimate is exact or one too high.
  assign prod    = 31'(x_q) * 31'd11651;
  assign quo_mul = 17'(quo_q) * 17'd360;
  assign diff    = {1'b0, x_q} - {1'b0, quo_mul};

  always_comb begin
    if (diff[17])                rem_d = 9'(diff + 18'd360);
    else if (diff >= 18'd360)    rem_d = 9'(diff - 18'd360);
    else                         rem_d = diff[8:0];
  end

  always_comb begin
    if (rem_q >= 9'd300)      hund = 2'd3;
    else if (rem_q >= 9'd200) hund = 2'd2;
    else if (rem_q >= 9'd100) hund = 2'd1;
    else                      hund = 2'd0;
    rem100 = 7'(rem_q - 9'(hund) * 9'd100);
    tens = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if (rem100 >= 7'(k * 10)) tens = tens + 4'd1;
    end
    units = 4'(rem100 - 7'(tens) * 7'd10);
  end

  always_comb begin
    tx_flag = 1'b1;
    tx_byte = CHAR_SEMI;
    case (cur_q.kind)
      JOB_TICK: begin
        case (idx_q[1:0])
          2'd0:    tx_byte = CHAR_A;
          2'd1:    tx_byte = (cur_q.am && !idx_q[2]) ? CHAR_M : CHAR_I;
          2'd2:    tx_byte = CHAR_ONE;
          default: tx_byte = CHAR_SEMI;
        endcase
      end
      JOB_TURN: begin
        case (idx_q)
          3'd0:    tx_byte = CHAR_A;
          3'd1:    tx_byte = CHAR_P;
          3'd2:    tx_byte = CHAR_ONE;
          3'd3:    tx_byte = CHAR_ZERO + 8'(dig_q[0]);
          3'd4:    tx_byte = CHAR_ZERO + 8'(dig_q[1]);
          3'd5:    tx_byte = CHAR_ZERO + 8'(dig_q[2]);
          default: tx_byte = CHAR_SEMI;
        endcase
      end
      JOB_STOP: tx_byte = CHAR_SEMI;
      default: begin
        tx_flag = 1'b0;
        tx_byte = 8'h00;
      end
    endcase
  end

  // free-running remainder pipeline; calc_q holds the job until it settles
  always_ff @(posedge clk_i) begin
    quo_q    <= prod[29:22];
    rem_q    <= rem_d;
    dig_q[0] <= 4'(hund);
    dig_q[1] <= tens;
    dig_q[2] <= units;
    if (pop_o) begin
      cur_q <= job_i;
      if (job_i.kind == JOB_TURN) x_q <= {~job_i.target[15], job_i.target[14:0]} + 17'd352;
    end
    if (fire) begin
      out_data_q <= {3'b000, cur_q.st.link_chg, cur_q.st.az_chg, cur_q.st.link_up,
                     cur_q.st.az_valid, cur_q.st.azimuth, tx_byte};
      out_tx_q   <= tx_flag;
      out_last_q <= (idx_q == last_idx_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_vld_q  <= 1'b0;
      idx_q      <= 3'd0;
      last_idx_q <= 3'd0;
      calc_q     <= 2'd0;
      out_vld_q  <= 1'b0;
    end else begin
      if (pop_o) begin
        cur_vld_q  <= 1'b1;
        idx_q      <= 3'd0;
        last_idx_q <= job_last;
        calc_q     <= (job_i.kind == JOB_TURN) ? 2'd3 : 2'd0;
      end else begin
        if (fire_last)  cur_vld_q <= 1'b0;
        else if (fire)  idx_q <= idx_q + 3'd1;
        if (calc_q != 2'd0) calc_q <= calc_q - 2'd1;
      end
      if (fire)             out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_data_q;
  assign out_tx_o    = out_tx_q;
  assign out_last_o  = out_last_q;

endmodule

### rtl/core/rsl_checker.sv
// ---------------------------------------------------------------------------
// rsl_checker
// Port-level checks on the result stream of the rotator serial link block.
// ---------------------------------------------------------------------------
`include "rotator_serial_link_top_defines.svh"

module rsl_checker import rsl_pkg::*; (
  input logic                   clk_i,
  input logic                   rst_ni,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tuser,
  input logic                   m_axis_tlast
);

  // hold a stalled result
  `RSL_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser) && $stable(m_axis_tlast), "stalled result changed")

  // a result without a byte is the only result of its event
  `RSL_ASSERT_OUT(a_silent_last, m_axis_tuser || (m_axis_tlast && (m_axis_tdata[7:0] == 8'h00)), "silent result not single")

  // link and azimuth are gained and lost together
  `RSL_ASSERT_OUT(a_link_az, m_axis_tdata[17] == m_axis_tdata[18], "azimuth validity differs from link")

  // unknown azimuth reads as zero
  `RSL_ASSERT_OUT(a_az_zero, m_axis_tdata[17] || (m_axis_tdata[16:8] == 9'd0), "unknown azimuth not zero")

endmodule

bind rotator_serial_link_top rsl_checker u_rsl_checker (.*);
